// ===== sv/bitmap_frame_allocator_assert.svh =====
// Assertion macros shared by the frame allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfa_pkg.sv =====
// Shared constants, types and state codes for the frame allocator.
package bfa_pkg;

    localparam int MAX_FRAMES      = 16384;
    localparam int RESERVED_FRAMES = 1024;
    localparam int MAP_BYTES       = MAX_FRAMES / 8;
    localparam int RES_BYTES       = RESERVED_FRAMES / 8;

    localparam int FRAME_W = 14;   // frame index
    localparam int COUNT_W = 15;   // frame count, frame total
    localparam int BYTE_W  = 11;   // map byte index
    localparam int PTR_W   = 12;   // map byte pointer, may hold MAP_BYTES
    localparam int BCNT_W  = 26;   // requested byte count

    localparam int FRAME_SHIFT = 12;           // 4 KB frames
    localparam int PAD_BYTES   = 4 + 4096 - 1; // header word plus round-up

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [7:0] BYTE_USED = 8'h00;
    localparam logic [7:0] BYTE_FREE = 8'hFF;

    typedef enum logic [1:0] {
        ST_INIT,   // clearing pass after reset
        ST_IDLE,
        ST_SCAN,   // first-fit search
        ST_UPD     // read-modify-write of a frame run
    } t_state;

    // run tracker carried from byte to byte during the search
    typedef struct packed {
        logic [COUNT_W-1:0] run;
        logic [FRAME_W-1:0] first;
    } t_run_st;

    typedef struct packed {
        logic [COUNT_W-1:0] run;
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] hit;    // last frame of the run when found
        logic               found;
    } t_run_res;

endpackage

// ===== sv/bfa_run_step.sv =====
// One map byte of the first-fit run search: eight frames, MSB first.
module bfa_run_step (
    input  logic [7:0]                   i_data,
    input  logic [bfa_pkg::BYTE_W-1:0]   i_byte,
    input  logic [bfa_pkg::COUNT_W-1:0]  i_need,
    input  bfa_pkg::t_run_st             i_st,
    output bfa_pkg::t_run_res            o_res
);

    logic [bfa_pkg::COUNT_W-1:0] w_run;
    logic [bfa_pkg::FRAME_W-1:0] w_first;
    logic [bfa_pkg::FRAME_W-1:0] w_hit;
    logic                        w_found;

    always_comb begin
        w_run   = i_st.run;
        w_first = i_st.first;
        w_hit   = '0;
        w_found = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (!w_found) begin
                if (i_data[7-j]) begin
                    if (w_run == '0) begin
                        w_first = {i_byte, 3'(j)};
                    end
                    w_run = w_run + 1'b1;
                    if (w_run == i_need) begin
                        w_found = 1'b1;
                        w_hit   = {i_byte, 3'(j)};
                    end
                end else begin
                    w_run = '0;
                end
            end
        end
        o_res = '{run: w_run, first: w_first, hit: w_hit, found: w_found};
    end

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// Top level: bitmap first-fit frame allocator with its free-map memory and sequencer.
//
// Usage
//   Command channel: drive i_cmd and its fields with i_start; the command is taken at a
//   rising edge where i_start is high and o_busy is low. i_cmd = alloc asks for
//   ceil((i_byte_count+4)/4096) frames; i_cmd = free sets i_free_count frames from
//   i_free_frame (clipped at the map end).
//   Result channel: one word per command, on o_ok/o_got_frame/o_got_count for exactly
//   the cycle o_done is high. The receiver cannot stall; capture it that cycle.
//   Config: i_cfg_we writes i_cfg_wdata into frame_total; write only while idle.
// Timing
//   Free map is a 2048 x 8 memory with one read and one write port; commands walk it
//   one byte per cycle.
//   Oversized alloc or zero-length free: result the cycle after the command.
//   Alloc: a scan of map bytes, then a rewrite of the bytes of the granted run; the scan
//   covers at most frame_total/8 - 128 bytes and holds the run.
//   Free: a rewrite of the map bytes touched by the run.
//   One command at a time; o_busy stays high until its result is issued.
// Reset
//   Synchronous, active low. frame_total returns to 16384, then a clearing pass over all
//   2048 map bytes rewrites the map (reserved frames used, all others free) with o_busy
//   high. Config writes are still taken during that pass.
module bitmap_frame_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cmd,
    input  logic [bfa_pkg::BCNT_W-1:0]    i_byte_count,
    input  logic [bfa_pkg::FRAME_W-1:0]   i_free_frame,
    input  logic [bfa_pkg::COUNT_W-1:0]   i_free_count,
    input  logic                          i_cfg_we,
    input  logic [bfa_pkg::COUNT_W-1:0]   i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [bfa_pkg::FRAME_W-1:0]   o_got_frame,
    output logic [bfa_pkg::COUNT_W-1:0]   o_got_count
);

`include "bitmap_frame_allocator_assert.svh"

    // ---------------- registers ----------------
    bfa_pkg::t_state                r_state, n_state;
    logic [bfa_pkg::PTR_W-1:0]      r_ptr, n_ptr;      // next map byte to read
    logic                           r_dval, n_dval;    // r_rdata holds a wanted byte
    logic [bfa_pkg::BYTE_W-1:0]     r_dptr, n_dptr;    // byte index of r_rdata
    logic [bfa_pkg::COUNT_W-1:0]    r_need, n_need;    // frames asked for
    logic [bfa_pkg::COUNT_W-1:0]    r_run, n_run;
    logic [bfa_pkg::FRAME_W-1:0]    r_first, n_first;
    logic [bfa_pkg::FRAME_W-1:0]    r_lo, n_lo;        // run to update, inclusive
    logic [bfa_pkg::FRAME_W-1:0]    r_hi, n_hi;
    logic [bfa_pkg::BYTE_W-1:0]     r_last, n_last;    // byte holding r_hi
    logic                           r_set, n_set;      // 1 free (set bits), 0 clear
    logic                           r_done, n_done;
    logic                           r_ok, n_ok;
    logic [bfa_pkg::FRAME_W-1:0]    r_got_frame, n_got_frame;
    logic [bfa_pkg::COUNT_W-1:0]    r_got_count, n_got_count;
    logic [bfa_pkg::COUNT_W-1:0]    r_frame_total;

    // free map, one bit per frame, lowest frame in the MSB
    logic [7:0]                     r_map [bfa_pkg::MAP_BYTES];
    logic [7:0]                     r_rdata;

    // ---------------- combinational helpers ----------------
    logic                           w_we;
    logic [bfa_pkg::BYTE_W-1:0]     w_waddr;
    logic [7:0]                     w_wdata;
    logic [bfa_pkg::COUNT_W-1:0]    w_eff;
    logic [bfa_pkg::PTR_W-1:0]      w_end;
    logic [bfa_pkg::COUNT_W-1:0]    w_usable;
    logic [bfa_pkg::BCNT_W:0]       w_bsum;
    logic [bfa_pkg::COUNT_W-1:0]    w_need;
    logic [bfa_pkg::COUNT_W:0]      w_free_end;
    logic [bfa_pkg::COUNT_W:0]      w_free_clip;
    logic [bfa_pkg::FRAME_W-1:0]    w_free_hi;
    logic [2:0]                     w_s;
    logic [2:0]                     w_e;
    logic [7:0]                     w_mask;
    bfa_pkg::t_run_st               w_st;
    bfa_pkg::t_run_res              w_res;

    // totals above the map act as the map size
    assign w_eff = (r_frame_total > bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES))
                 ? bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES) : r_frame_total;
    // search stops before the partial last byte
    assign w_end = w_eff[bfa_pkg::COUNT_W-1:3];
    assign w_usable = (w_eff > bfa_pkg::COUNT_W'(bfa_pkg::RESERVED_FRAMES))
                    ? w_eff - bfa_pkg::COUNT_W'(bfa_pkg::RESERVED_FRAMES) : '0;

    // frames = ceil((bytes + header) / 4096)
    assign w_bsum = {1'b0, i_byte_count} + (bfa_pkg::BCNT_W+1)'(bfa_pkg::PAD_BYTES);
    assign w_need = w_bsum[bfa_pkg::BCNT_W:bfa_pkg::FRAME_SHIFT];

    // free run end, clipped at the map end
    assign w_free_end  = {2'b00, i_free_frame} + {1'b0, i_free_count};
    assign w_free_clip = (w_free_end > (bfa_pkg::COUNT_W+1)'(bfa_pkg::MAX_FRAMES))
                       ? (bfa_pkg::COUNT_W+1)'(bfa_pkg::MAX_FRAMES) : w_free_end;
    assign w_free_hi   = bfa_pkg::FRAME_W'(w_free_clip - 1'b1);

    // bits of byte r_dptr inside [r_lo, r_hi]
    assign w_s = (r_dptr == r_lo[bfa_pkg::FRAME_W-1:3]) ? r_lo[2:0] : 3'd0;
    assign w_e = (r_dptr == r_hi[bfa_pkg::FRAME_W-1:3]) ? r_hi[2:0] : 3'd7;
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_mask[7-j] = (3'(j) >= w_s) && (3'(j) <= w_e);
        end
    end

    // search step over the byte just read
    assign w_st = '{run: r_run, first: r_first};

    bfa_run_step u_step (
        .i_data (r_rdata),
        .i_byte (r_dptr),
        .i_need (r_need),
        .i_st   (w_st),
        .o_res  (w_res)
    );

    // ---------------- memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        r_rdata <= r_map[r_ptr[bfa_pkg::BYTE_W-1:0]];
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bfa_pkg::ST_INIT;
            r_ptr         <= '0;
            r_dval        <= 1'b0;
            r_done        <= 1'b0;
            r_frame_total <= bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES);
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_dval  <= n_dval;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_frame_total <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dptr      <= n_dptr;
        r_need      <= n_need;
        r_run       <= n_run;
        r_first     <= n_first;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_last      <= n_last;
        r_set       <= n_set;
        r_ok        <= n_ok;
        r_got_frame <= n_got_frame;
        r_got_count <= n_got_count;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_dval      = 1'b0;
        n_dptr      = r_ptr[bfa_pkg::BYTE_W-1:0];
        n_need      = r_need;
        n_run       = r_run;
        n_first     = r_first;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_last      = r_last;
        n_set       = r_set;
        n_done      = 1'b0;
        n_ok        = r_ok;
        n_got_frame = r_got_frame;
        n_got_count = r_got_count;
        w_we        = 1'b0;
        w_waddr     = r_dptr;
        w_wdata     = r_set ? (r_rdata | w_mask) : (r_rdata & ~w_mask);

        unique case (r_state)
            bfa_pkg::ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[bfa_pkg::BYTE_W-1:0];
                w_wdata = (r_ptr < bfa_pkg::PTR_W'(bfa_pkg::RES_BYTES))
                        ? bfa_pkg::BYTE_USED : bfa_pkg::BYTE_FREE;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr[bfa_pkg::BYTE_W-1:0] == bfa_pkg::BYTE_W'(bfa_pkg::MAP_BYTES - 1)) begin
                    n_state = bfa_pkg::ST_IDLE;
                end
            end

            bfa_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_cmd == bfa_pkg::CMD_ALLOC) begin
                        if (w_need > w_usable) begin
                            // too large: fail without a search
                            n_done      = 1'b1;
                            n_ok        = 1'b0;
                            n_got_frame = '0;
                            n_got_count = '0;
                        end else begin
                            n_need  = w_need;
                            n_run   = '0;
                            n_first = '0;
                            n_ptr   = bfa_pkg::PTR_W'(bfa_pkg::RES_BYTES);
                            n_state = bfa_pkg::ST_SCAN;
                        end
                    end else begin
                        n_got_frame = '0;
                        n_got_count = '0;
                        if (i_free_count == '0) begin
                            n_done = 1'b1;
                            n_ok   = 1'b1;
                        end else begin
                            n_lo    = i_free_frame;
                            n_hi    = w_free_hi;
                            n_last  = w_free_hi[bfa_pkg::FRAME_W-1:3];
                            n_set   = 1'b1;
                            n_ptr   = {1'b0, i_free_frame[bfa_pkg::FRAME_W-1:3]};
                            n_state = bfa_pkg::ST_UPD;
                        end
                    end
                end
            end

            bfa_pkg::ST_SCAN: begin
                if (r_dval) begin
                    n_run   = w_res.run;
                    n_first = w_res.first;
                end
                if (r_dval && w_res.found) begin
                    // grant [first, hit]; clear it
                    n_lo        = w_res.first;
                    n_hi        = w_res.hit;
                    n_last      = w_res.hit[bfa_pkg::FRAME_W-1:3];
                    n_set       = 1'b0;
                    n_ptr       = {1'b0, w_res.first[bfa_pkg::FRAME_W-1:3]};
                    n_got_frame = w_res.first;
                    n_got_count = r_need;
                    n_state     = bfa_pkg::ST_UPD;
                end else if (r_ptr < w_end) begin
                    n_dval = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end else if (!r_dval) begin
                    // range exhausted
                    n_done      = 1'b1;
                    n_ok        = 1'b0;
                    n_got_frame = '0;
                    n_got_count = '0;
                    n_state     = bfa_pkg::ST_IDLE;
                end
            end

            bfa_pkg::ST_UPD: begin
                // read byte k while writing back byte k-1
                if (r_ptr <= {1'b0, r_last}) begin
                    n_dval = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end
                if (r_dval) begin
                    w_we    = 1'b1;
                    w_waddr = r_dptr;
                    if (r_dptr == r_last) begin
                        n_done  = 1'b1;
                        n_ok    = 1'b1;
                        n_state = bfa_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = bfa_pkg::ST_INIT;
            end
        endcase
    end

    assign o_busy      = (r_state != bfa_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_got_frame = r_got_frame;
    assign o_got_count = r_got_count;

    // ---------------- assertions ----------------
    `BFA_ASSERT_NEXT(a_cmd_acted, i_start && !o_busy, o_done || o_busy, "command taken but neither result nor busy")
    `BFA_ASSERT_NOW(a_fail_zero, o_done && !o_ok, o_got_frame == '0 && o_got_count == '0, "failed allocate returned a run")
    `BFA_ASSERT_NOW(a_grant_above_res, o_done && o_got_count != '0, o_got_frame >= bfa_pkg::FRAME_W'(bfa_pkg::RESERVED_FRAMES), "granted run inside reserved frames")
    `BFA_ASSERT_NOW(a_upd_in_run, r_state == bfa_pkg::ST_UPD && r_dval, r_dptr <= r_last, "update wrote past the run")

endmodule
